// ===== rtl/ansi_truecolor_cell_encoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the terminal cell encoder
// Implication checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ANSI_TRUECOLOR_CELL_ENCODER_TOP_ASSERT_SVH
`define ANSI_TRUECOLOR_CELL_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ATE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ATE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ATE_ASSERT_IMPL(lbl, ante, cons, msg)
`define ATE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/ate_pkg.sv =====
// ----------------------------------------------------------------------------
// ate_pkg
// Types, byte codes and glyph tables shared by the cell encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ate_pkg;

  localparam int CfgW = 13;
  localparam logic [CfgW-1:0] ColumnsReset = 13'd80;
  localparam logic [CfgW-1:0] RowsReset    = 13'd50;

  // register indexes
  localparam logic RegColumns = 1'b0;
  localparam logic RegRows    = 1'b1;

  localparam int CmdDepth = 4;

  // terminal bytes
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChLbr   = 8'h5B;
  localparam logic [7:0] ChHome  = 8'h48;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChThree = 8'h33;
  localparam logic [7:0] ChFour  = 8'h34;
  localparam logic [7:0] ChEight = 8'h38;
  localparam logic [7:0] ChSgr   = 8'h6D;
  localparam logic [7:0] ChNl    = 8'h0A;

  // one classified cell
  typedef struct packed {
    logic            home;
    logic            fch;
    logic            bch;
    logic [2:0][2:0] fg_dig;   // cube digits, [0] red
    logic [2:0][2:0] bg_dig;
    logic [2:0][7:0] utf8;     // [0] sent first
    logic [1:0]      utf8_len;
    logic            newline;
    logic            frame_end;
  } cmd_t;

  localparam logic [15:0] LowGlyphs [32] = '{
    16'h0020, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
    16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
    16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
    16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC
  };

  localparam logic [15:0] HighGlyphs [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h0020
  };

  function automatic logic [15:0] glyph_code(input logic [7:0] g);
    logic [15:0] cp;
    if (g < 8'd32) begin
      cp = LowGlyphs[g[4:0]];
    end else if (g < 8'd127) begin
      cp = {8'h00, g};
    end else if (g == 8'd127) begin
      cp = 16'h2302;
    end else begin
      cp = HighGlyphs[g[6:0]];
    end
    return cp;
  endfunction

  // decimal text of 51 * d, first character in [0]
  function automatic logic [2:0][7:0] comp_text(input logic [2:0] d);
    logic [2:0][7:0] t;
    case (d)
      3'd1:    t = {8'h00, 8'h31, 8'h35};
      3'd2:    t = {8'h32, 8'h30, 8'h31};
      3'd3:    t = {8'h33, 8'h35, 8'h31};
      3'd4:    t = {8'h34, 8'h30, 8'h32};
      3'd5:    t = {8'h35, 8'h35, 8'h32};
      default: t = {8'h00, 8'h00, 8'h30};
    endcase
    return t;
  endfunction

  function automatic logic [1:0] comp_len(input logic [2:0] d);
    logic [1:0] n;
    case (d)
      3'd1:                   n = 2'd2;
      3'd2, 3'd3, 3'd4, 3'd5: n = 2'd3;
      default:                n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ate_front.sv =====
// ----------------------------------------------------------------------------
// ate_front
// Accepts cells, tracks frame position and colours, and classifies each
// cell into a command for the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ate_front #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  input  wire logic                      cmd_full_i,
  input  wire logic [7:0]                glyph_i,
  input  wire logic [7:0]                fore_index_i,
  input  wire logic [7:0]                back_index_i,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [ate_pkg::CfgW-1:0]  cfg_data_i,
  output logic                           cmd_push_o,
  output ate_pkg::cmd_t                  cmd_o
);

  localparam int CntW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int CmpW = (CntW + 1 > ate_pkg::CfgW) ? CntW + 1 : ate_pkg::CfgW;

  logic [ate_pkg::CfgW-1:0] columns_q, rows_q;
  logic [CntW-1:0]          column_q, column_d, row_q, row_d;
  logic [7:0]               last_fore_q, last_back_q;
  logic                     known_q;

  logic                     accept;
  logic [CmpW-1:0]          cols_eff, rows_eff, col_inc, row_inc;
  logic                     row_wrap, frame_wrap, known_eff;
  logic [15:0]              cp;

  function automatic logic [CmpW-1:0] clamp_dim(input logic [ate_pkg::CfgW-1:0] v);
    logic [CmpW-1:0] w;
    w = CmpW'(v);
    if (w == '0) begin
      w = CmpW'(1);
    end else if (w > CmpW'(MAX_DIM)) begin
      w = CmpW'(MAX_DIM);
    end
    return w;
  endfunction

  // split a cube index into its three base-6 digits
  function automatic logic [2:0][2:0] colour_digits(input logic [7:0] idx);
    logic [7:0]      v;
    logic [13:0]     p36;
    logic [2:0]      r;
    logic [5:0]      rem;
    logic [10:0]     p6;
    logic [2:0]      g;
    logic [5:0]      b;
    logic [2:0][2:0] dig;
    v   = idx - 8'd16;
    p36 = {6'd0, v} * 14'd57;
    r   = p36[13:11];
    rem = 6'(v - 8'(r * 6'd36));
    p6  = {5'd0, rem} * 11'd43;
    g   = p6[10:8];
    b   = rem - 6'(g * 3'd6);
    dig = {b[2:0], g, r};
    if (idx < 8'd16 || idx > 8'd231) begin
      dig = '0;
    end
    return dig;
  endfunction

  assign accept     = push && !cmd_full_i;
  assign cmd_push_o = accept;

  assign cols_eff   = clamp_dim(columns_q);
  assign rows_eff   = clamp_dim(rows_q);
  assign col_inc    = CmpW'(column_q) + CmpW'(1);
  assign row_inc    = CmpW'(row_q) + CmpW'(1);
  assign row_wrap   = col_inc >= cols_eff;
  assign frame_wrap = row_wrap && (row_inc >= rows_eff);

  assign cp = ate_pkg::glyph_code(glyph_i);

  always_comb begin
    cmd_o.home     = (column_q == '0) && (row_q == '0);
    known_eff      = known_q && !cmd_o.home;
    cmd_o.fch      = !known_eff || (fore_index_i != last_fore_q);
    cmd_o.bch      = !known_eff || (back_index_i != last_back_q);
    cmd_o.fg_dig   = colour_digits(fore_index_i);
    cmd_o.bg_dig   = colour_digits(back_index_i);
    if (cp < 16'h0080) begin
      cmd_o.utf8     = {8'h00, 8'h00, cp[7:0]};
      cmd_o.utf8_len = 2'd1;
    end else if (cp < 16'h0800) begin
      cmd_o.utf8     = {8'h00, {2'b10, cp[5:0]}, {3'b110, cp[10:6]}};
      cmd_o.utf8_len = 2'd2;
    end else begin
      cmd_o.utf8     = {{2'b10, cp[5:0]}, {2'b10, cp[11:6]}, {4'b1110, cp[15:12]}};
      cmd_o.utf8_len = 2'd3;
    end
    cmd_o.newline   = row_wrap && !frame_wrap;
    cmd_o.frame_end = frame_wrap;
  end

  always_comb begin
    column_d = column_q;
    row_d    = row_q;
    if (row_wrap) begin
      column_d = '0;
      row_d    = frame_wrap ? '0 : row_inc[CntW-1:0];
    end else begin
      column_d = col_inc[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q   <= ate_pkg::ColumnsReset;
      rows_q      <= ate_pkg::RowsReset;
      column_q    <= '0;
      row_q       <= '0;
      last_fore_q <= '0;
      last_back_q <= '0;
      known_q     <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == ate_pkg::RegColumns) begin
        columns_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == ate_pkg::RegRows) begin
        rows_q <= cfg_data_i;
      end
      if (accept) begin
        column_q    <= column_d;
        row_q       <= row_d;
        last_fore_q <= fore_index_i;
        last_back_q <= back_index_i;
        known_q     <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ate_fifo.sv =====
// ----------------------------------------------------------------------------
// ate_fifo
// Short command queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ate_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ate_pkg::cmd_t data_i,
  input  wire logic          pop_i,
  output ate_pkg::cmd_t      head_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int PtrW = $clog2(ate_pkg::CmdDepth);

  ate_pkg::cmd_t   mem_q [ate_pkg::CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == (PtrW + 1)'(ate_pkg::CmdDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (PtrW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (PtrW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ate_back.sv =====
// ----------------------------------------------------------------------------
// ate_back
// Byte sequencer: walks the queue head command, emitting one terminal byte
// per cycle to the output register unless the queue is empty or output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ate_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ate_pkg::cmd_t cmd_i,
  input  wire logic          cmd_empty_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  wire logic          pop,
  output logic [7:0]         out_byte_o,
  output logic               last_of_cell_o,
  output logic               end_of_frame_o
);

  localparam logic [3:0] StStart = 4'd0;
  localparam logic [3:0] StHome  = 4'd1;
  localparam logic [3:0] StCsi   = 4'd2;
  localparam logic [3:0] StHead  = 4'd3;
  localparam logic [3:0] StSemi  = 4'd4;
  localparam logic [3:0] StDig   = 4'd5;
  localparam logic [3:0] StSep   = 4'd6;
  localparam logic [3:0] StSgr   = 4'd7;
  localparam logic [3:0] StGlyph = 4'd8;
  localparam logic [3:0] StNl    = 4'd9;

  logic [3:0] state_q, state_d, cur_state;
  logic [1:0] idx_q, idx_d;
  logic [1:0] k_q, k_d;
  logic       bgsel_q, bgsel_d;

  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       last_q, eof_q;

  logic       advance, done;
  logic [7:0] byte_c;
  logic       eof_c;
  logic [2:0] dig;
  logic [2:0][7:0] dig_text;

  assign advance = !cmd_empty_i && (!out_valid_q || pop);
  assign dig      = bgsel_q ? cmd_i.bg_dig[k_q] : cmd_i.fg_dig[k_q];
  assign dig_text = ate_pkg::comp_text(dig);

  // the start state resolves against the queue head
  always_comb begin
    cur_state = state_q;
    if (state_q == StStart) begin
      if (cmd_i.home) begin
        cur_state = StHome;
      end else if (cmd_i.fch || cmd_i.bch) begin
        cur_state = StCsi;
      end else begin
        cur_state = StGlyph;
      end
    end
  end

  always_comb begin
    state_d = cur_state;
    idx_d   = idx_q + 2'd1;
    k_d     = k_q;
    bgsel_d = bgsel_q;
    byte_c  = ate_pkg::ChNl;
    done    = 1'b0;
    unique case (cur_state)
      StHome: begin
        byte_c = (idx_q == 2'd0) ? ate_pkg::ChEsc :
                 (idx_q == 2'd1) ? ate_pkg::ChLbr : ate_pkg::ChHome;
        if (idx_q == 2'd2) begin
          idx_d   = 2'd0;
          state_d = (cmd_i.fch || cmd_i.bch) ? StCsi : StGlyph;
        end
      end
      StCsi: begin
        byte_c = (idx_q == 2'd0) ? ate_pkg::ChEsc : ate_pkg::ChLbr;
        if (idx_q == 2'd1) begin
          idx_d   = 2'd0;
          bgsel_d = !cmd_i.fch;
          state_d = StHead;
        end
      end
      StHead: begin
        case (idx_q)
          2'd0:    byte_c = bgsel_q ? ate_pkg::ChFour : ate_pkg::ChThree;
          2'd1:    byte_c = ate_pkg::ChEight;
          2'd2:    byte_c = ate_pkg::ChSemi;
          default: byte_c = ate_pkg::ChTwo;
        endcase
        if (idx_q == 2'd3) begin
          idx_d   = 2'd0;
          k_d     = 2'd0;
          state_d = StSemi;
        end
      end
      StSemi: begin
        byte_c  = ate_pkg::ChSemi;
        idx_d   = 2'd0;
        state_d = StDig;
      end
      StDig: begin
        byte_c = dig_text[idx_q];
        if (idx_q == ate_pkg::comp_len(dig) - 2'd1) begin
          idx_d = 2'd0;
          if (k_q == 2'd2) begin
            k_d     = 2'd0;
            state_d = (!bgsel_q && cmd_i.bch) ? StSep : StSgr;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = StSemi;
          end
        end
      end
      StSep: begin
        byte_c  = ate_pkg::ChSemi;
        idx_d   = 2'd0;
        bgsel_d = 1'b1;
        state_d = StHead;
      end
      StSgr: begin
        byte_c  = ate_pkg::ChSgr;
        idx_d   = 2'd0;
        state_d = StGlyph;
      end
      StGlyph: begin
        byte_c = cmd_i.utf8[idx_q];
        if (idx_q == cmd_i.utf8_len - 2'd1) begin
          idx_d = 2'd0;
          if (cmd_i.newline) begin
            state_d = StNl;
          end else begin
            done = 1'b1;
          end
        end
      end
      StNl: begin
        byte_c = ate_pkg::ChNl;
        idx_d  = 2'd0;
        done   = 1'b1;
      end
      default: begin
        idx_d   = 2'd0;
        state_d = StStart;
      end
    endcase
    eof_c = done && cmd_i.frame_end;
    if (done) begin
      state_d = StStart;
      k_d     = 2'd0;
      bgsel_d = 1'b0;
    end
  end

  assign cmd_pop_o = advance && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StStart;
      idx_q       <= '0;
      k_q         <= '0;
      bgsel_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        idx_q       <= idx_d;
        k_q         <= k_d;
        bgsel_q     <= bgsel_d;
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= byte_c;
      last_q <= done;
      eof_q  <= eof_c;
    end
  end

  assign empty          = !out_valid_q;
  assign out_byte_o     = byte_q;
  assign last_of_cell_o = last_q;
  assign end_of_frame_o = eof_q;

endmodule

`default_nettype wire

// ===== rtl/ansi_truecolor_cell_encoder_top.sv =====
// A cell accepted at the input goes into the command queue; the sequencer
// registers its first byte from the queue head onto the result ports.
// Throughput: one output byte per cycle, set by the byte sequencer, while
// commands wait and bytes are popped; a cell causes 1 to 43 bytes.
// Reset clears frame position and colours, loads columns 80 and rows 50,
// and empties the queue and the output register; no clearing pass is needed.
`default_nettype none

`include "ansi_truecolor_cell_encoder_top_assert.svh"

// ----------------------------------------------------------------------------
// ansi_truecolor_cell_encoder_top
// Character cells in, terminal bytes with truecolour escapes out.
// ----------------------------------------------------------------------------
module ansi_truecolor_cell_encoder_top #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [7:0]                glyph_i,
  input  wire logic [7:0]                fore_index_i,
  input  wire logic [7:0]                back_index_i,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [7:0]                     out_byte_o,
  output logic                           last_of_cell_o,
  output logic                           end_of_frame_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [ate_pkg::CfgW-1:0]  cfg_data_i
);

  ate_pkg::cmd_t front_cmd, head_cmd;
  logic          cmd_push, cmd_pop, cmd_full, cmd_empty;

  assign full = cmd_full;

  ate_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .cmd_full_i   (cmd_full),
    .glyph_i      (glyph_i),
    .fore_index_i (fore_index_i),
    .back_index_i (back_index_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_push_o   (cmd_push),
    .cmd_o        (front_cmd)
  );

  ate_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .pop_i   (cmd_pop),
    .head_o  (head_cmd),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  ate_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (head_cmd),
    .cmd_empty_i    (cmd_empty),
    .cmd_pop_o      (cmd_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .last_of_cell_o (last_of_cell_o),
    .end_of_frame_o (end_of_frame_o)
  );

  `ATE_ASSERT_IMPL(a_eof_ends_cell, !empty && end_of_frame_o, last_of_cell_o, "eof without last")
  `ATE_ASSERT_IMPL(a_queue_flags, cmd_full, !cmd_empty, "command queue full and empty at once")
  `ATE_ASSERT_IMPL(a_pop_has_cmd, cmd_pop, !cmd_empty, "pop from empty command queue")
  `ATE_ASSERT_NEXT(a_retire_shows_last, cmd_pop, !empty && last_of_cell_o, "missing last byte")

endmodule

`default_nettype wire
